FILE: sv/sce_pkg.sv
package sce_pkg;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      REG_STEP_THRESHOLD   = 2'd0,
      REG_MAX_CADENCE      = 2'd1,
      REG_MIN_CADENCE      = 2'd2,
      REG_SMOOTHING_WEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_THRESHOLD,
      ST_MAX_LIMIT,
      ST_MIN_LIMIT,
      ST_DIVIDE,
      ST_SMOOTH_MUL,
      ST_SMOOTH_SUM,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   localparam logic [31:0] STEP_THRESHOLD_RESET = 32'd67108864;
   localparam logic [7:0]  MAX_CADENCE_RESET    = 8'd230;
   localparam logic [7:0]  MIN_CADENCE_RESET    = 8'd20;
   localparam logic [8:0]  SMOOTH_WEIGHT_RESET  = 9'd23;
   localparam logic [8:0]  WEIGHT_FULL          = 9'd256;
   localparam logic [25:0] ROUND_HALF           = 26'd128;
   localparam logic [15:0] CADENCE_SAT          = 16'hFFFF;

   localparam int unsigned CADENCE_NUMERATOR = 60000;
   localparam int unsigned AVERAGE_RESET_INT = 110;
   localparam int unsigned NUMERATOR_WIDTH   = 16;

   // An accepted step has an interval of at least 236 ms (60000 / 255), so
   // the top seven quotient bits of the cadence division are always zero.
   localparam int unsigned DIV_SKIP_BITS = 7;

endpackage

FILE: sv/sce_sqsum.sv
module sce_sqsum (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [15:0]       ax,
   input  logic signed [15:0]       ay,
   input  logic signed [15:0]       az,
   output sce_pkg::unit_status_type status,
   output logic [31:0]              mag
);

   logic [1:0]  axis_ff, axis_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] acc_ff, acc_in;
   logic signed [15:0] sel;
   logic [15:0] abs_val;
   logic [31:0] square;

   always_comb begin
      unique case (axis_ff)
         2'd0:    sel = ax;
         2'd1:    sel = ay;
         default: sel = az;
      endcase
      // Negating the most negative count wraps to 0x8000, which is 32768 unsigned.
      abs_val = sel[15] ? 16'(-sel) : 16'(sel);
      square  = 32'(abs_val) * 32'(abs_val);

      axis_in = axis_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      acc_in  = acc_ff;
      if (start) begin
         axis_in = 2'd0;
         busy_in = 1'b1;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in  = acc_ff + square;
         axis_in = axis_ff + 2'd1;
         if (axis_ff == 2'd2) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         axis_ff <= axis_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign mag         = acc_ff;

endmodule

FILE: sv/sce_div.sv
module sce_div #(
   parameter int unsigned DIV_W    = 24,
   parameter int unsigned SKIP     = 7,
   parameter logic [DIV_W-1:0] DIVIDEND = '0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [31:0]              divisor,
   output sce_pkg::unit_status_type status,
   output logic [DIV_W-SKIP-1:0]    quotient
);

   localparam int unsigned ITER  = DIV_W - SKIP;
   localparam int unsigned CNT_W = $clog2(ITER + 1);

   logic [31:0]       rem_ff, rem_in;
   logic [DIV_W-1:0]  dvd_ff, dvd_in;
   logic [ITER-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [32:0]       trial;

   always_comb begin
      // One quotient bit per cycle: shift the next dividend bit into the
      // partial remainder and subtract the divisor where it fits.
      trial  = {rem_ff, dvd_ff[DIV_W-1]} - {1'b0, divisor};
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = 32'(DIVIDEND[DIV_W-1 -: SKIP]);
         dvd_in = DIVIDEND << SKIP;
         quo_in = '0;
         cnt_in = CNT_W'(ITER);
      end else if (cnt_ff != '0) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
         end else begin
            rem_in = {rem_ff[30:0], dvd_ff[DIV_W-1]};
         end
         quo_in = {quo_ff[ITER-2:0], ~trial[32]};
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
   end

   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

FILE: sv/step_cadence_estimator_core.sv
// Channel    Direction  Handshake               Payload
// req_       in         req_valid / req_ready   sensor_id, batch_start, accel_x/y/z, time_ms
// rsp_       out        rsp_valid / rsp_ready   step_accepted, average_updated, step_cadence,
//                                               smoothed_cadence, active_sensor
// csr_       in         csr_we                  csr_index, csr_wdata
//
// One item at a time. An ignored sample goes straight to hand-off; one below threshold
// stops after squaring. An accepted step also runs the limits, 9 + CADENCE_FRAC_BITS
// quotient bits from the bit-serial divider, smoothing and hand-off. Squaring uses one
// 16x16 multiplier for the three axes in turn.
// A result waits in the output register while the next item is accepted.
// reset is synchronous and active high; it restores configuration and block state.
module step_cadence_estimator_core #(
   parameter int unsigned CADENCE_FRAC_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_sensor_id,
   input  logic               req_batch_start,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic [31:0]        req_time_ms,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_step_accepted,
   output logic               rsp_average_updated,
   output logic [15:0]        rsp_step_cadence,
   output logic [15:0]        rsp_smoothed_cadence,
   output logic               rsp_active_sensor,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int unsigned DIV_W  = sce_pkg::NUMERATOR_WIDTH + CADENCE_FRAC_BITS;
   localparam int unsigned QUO_W  = DIV_W - sce_pkg::DIV_SKIP_BITS;
   localparam logic [DIV_W-1:0] DIVIDEND =
      DIV_W'(sce_pkg::CADENCE_NUMERATOR) << CADENCE_FRAC_BITS;
   localparam logic [15:0] AVERAGE_RESET =
      16'(sce_pkg::AVERAGE_RESET_INT << CADENCE_FRAC_BITS);
   localparam logic [39:0] NUMERATOR_40 = 40'(sce_pkg::CADENCE_NUMERATOR);

   sce_pkg::state_type state_ff, state_in;

   // Configuration.
   logic [31:0] threshold_ff;
   logic [7:0]  max_cad_ff;
   logic [7:0]  min_cad_ff;
   logic [8:0]  weight_ff;

   // Block state.
   logic [31:0] last_time_ff;
   logic [15:0] average_ff;
   logic        sensor_ff;
   logic        closed_ff;

   // Item in flight.
   logic signed [15:0] ax_ff, ay_ff, az_ff;
   logic [31:0] time_ff;
   logic [31:0] interval_ff;
   logic        accepted_ff;
   logic        updated_ff;
   logic        smooth_ok_ff;
   logic [15:0] cad_ff;
   logic [24:0] prod_ff;

   // Output register.
   logic        rsp_valid_ff;
   logic        rsp_accepted_ff;
   logic        rsp_updated_ff;
   logic [15:0] rsp_cad_ff;
   logic [15:0] rsp_avg_ff;
   logic        rsp_sensor_ff;

   logic        sq_start;
   logic        div_start;
   logic        req_take;
   logic        closed_now;
   logic        eligible;
   logic        out_free;
   logic        reject;
   logic [39:0] max_prod;
   logic [39:0] min_prod;
   logic [8:0]  weight_sat;
   logic [25:0] smooth_sum;
   logic [17:0] smooth_avg;
   logic [31:0] quo_wide;
   logic [15:0] cad_sat;

   sce_pkg::unit_status_type sq_status;
   sce_pkg::unit_status_type div_status;
   logic [31:0]      mag;
   logic [QUO_W-1:0] quotient;

   sce_sqsum u_sqsum (
      .clock  (clock),
      .reset  (reset),
      .start  (sq_start),
      .ax     (ax_ff),
      .ay     (ay_ff),
      .az     (az_ff),
      .status (sq_status),
      .mag    (mag)
   );

   sce_div #(
      .DIV_W    (DIV_W),
      .SKIP     (sce_pkg::DIV_SKIP_BITS),
      .DIVIDEND (DIVIDEND)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (interval_ff),
      .status   (div_status),
      .quotient (quotient)
   );

   always_comb begin
      req_take   = req_valid && req_ready;
      closed_now = req_batch_start ? 1'b0 : closed_ff;
      eligible   = (req_sensor_id == sensor_ff) && !closed_now;
      out_free   = !rsp_valid_ff || rsp_ready;
      max_prod   = 40'(max_cad_ff) * 40'(interval_ff);
      min_prod   = 40'(min_cad_ff) * 40'(interval_ff);
      reject     = (interval_ff == '0) || (NUMERATOR_40 > max_prod);
      weight_sat = (weight_ff > sce_pkg::WEIGHT_FULL) ? sce_pkg::WEIGHT_FULL : weight_ff;
      smooth_sum = 26'(prod_ff)
                 + 26'(sce_pkg::WEIGHT_FULL - weight_sat) * 26'(average_ff)
                 + sce_pkg::ROUND_HALF;
      smooth_avg = smooth_sum[25:8];
      quo_wide   = 32'(quotient);
      cad_sat    = (quo_wide > 32'(sce_pkg::CADENCE_SAT)) ? sce_pkg::CADENCE_SAT
                                                         : quo_wide[15:0];
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      sq_start  = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         sce_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (eligible) begin
                  sq_start = 1'b1;
                  state_in = sce_pkg::ST_SQUARE;
               end else begin
                  state_in = sce_pkg::ST_FINISH;
               end
            end
         end
         sce_pkg::ST_SQUARE: begin
            if (sq_status.done) begin
               state_in = sce_pkg::ST_THRESHOLD;
            end
         end
         sce_pkg::ST_THRESHOLD: begin
            state_in = (mag > threshold_ff) ? sce_pkg::ST_MAX_LIMIT : sce_pkg::ST_FINISH;
         end
         sce_pkg::ST_MAX_LIMIT: begin
            state_in = reject ? sce_pkg::ST_FINISH : sce_pkg::ST_MIN_LIMIT;
         end
         sce_pkg::ST_MIN_LIMIT: begin
            div_start = 1'b1;
            state_in  = sce_pkg::ST_DIVIDE;
         end
         sce_pkg::ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = smooth_ok_ff ? sce_pkg::ST_SMOOTH_MUL : sce_pkg::ST_FINISH;
            end
         end
         sce_pkg::ST_SMOOTH_MUL: begin
            state_in = sce_pkg::ST_SMOOTH_SUM;
         end
         sce_pkg::ST_SMOOTH_SUM: begin
            state_in = sce_pkg::ST_FINISH;
         end
         sce_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = sce_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sce_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sce_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= sce_pkg::STEP_THRESHOLD_RESET;
         max_cad_ff   <= sce_pkg::MAX_CADENCE_RESET;
         min_cad_ff   <= sce_pkg::MIN_CADENCE_RESET;
         weight_ff    <= sce_pkg::SMOOTH_WEIGHT_RESET;
      end else if (csr_we) begin
         unique case (sce_pkg::csr_index_type'(csr_index))
            sce_pkg::REG_STEP_THRESHOLD:   threshold_ff <= csr_wdata;
            sce_pkg::REG_MAX_CADENCE:      max_cad_ff   <= csr_wdata[7:0];
            sce_pkg::REG_MIN_CADENCE:      min_cad_ff   <= csr_wdata[7:0];
            sce_pkg::REG_SMOOTHING_WEIGHT: weight_ff    <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // Block state and per-item registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         average_ff   <= AVERAGE_RESET;
         sensor_ff    <= 1'b1;
         closed_ff    <= 1'b0;
         accepted_ff  <= 1'b0;
         updated_ff   <= 1'b0;
         smooth_ok_ff <= 1'b0;
      end else begin
         if (req_take) begin
            closed_ff   <= closed_now;
            accepted_ff <= 1'b0;
            updated_ff  <= 1'b0;
         end
         if (state_ff == sce_pkg::ST_THRESHOLD && mag > threshold_ff) begin
            // The first crossing closes the batch whether or not the step is kept.
            closed_ff <= 1'b1;
         end
         if (state_ff == sce_pkg::ST_MIN_LIMIT) begin
            accepted_ff  <= 1'b1;
            last_time_ff <= time_ff;
            sensor_ff    <= ~sensor_ff;
            smooth_ok_ff <= !(NUMERATOR_40 < min_prod);
         end
         if (state_ff == sce_pkg::ST_SMOOTH_SUM) begin
            average_ff <= (smooth_avg > 18'(sce_pkg::CADENCE_SAT)) ? sce_pkg::CADENCE_SAT
                                                                  : smooth_avg[15:0];
            updated_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         ax_ff   <= req_accel_x;
         ay_ff   <= req_accel_y;
         az_ff   <= req_accel_z;
         time_ff <= req_time_ms;
         cad_ff  <= '0;
      end
      if (state_ff == sce_pkg::ST_THRESHOLD) begin
         interval_ff <= time_ff - last_time_ff;
      end
      if (state_ff == sce_pkg::ST_DIVIDE && div_status.done) begin
         cad_ff <= cad_sat;
      end
      if (state_ff == sce_pkg::ST_SMOOTH_MUL) begin
         prod_ff <= 25'(weight_sat) * 25'(cad_ff);
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == sce_pkg::ST_FINISH && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == sce_pkg::ST_FINISH && out_free) begin
         rsp_accepted_ff <= accepted_ff;
         rsp_updated_ff  <= updated_ff;
         rsp_cad_ff      <= cad_ff;
         rsp_avg_ff      <= average_ff;
         rsp_sensor_ff   <= sensor_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_step_accepted    = rsp_accepted_ff;
   assign rsp_average_updated  = rsp_updated_ff;
   assign rsp_step_cadence     = rsp_cad_ff;
   assign rsp_smoothed_cadence = rsp_avg_ff;
   assign rsp_active_sensor    = rsp_sensor_ff;

endmodule
